// ----- sv/srct_pkg.sv -----
// Shared constants for the shadow ray / capped cylinder test pipeline.
// No dependencies; used by the divider, the square root unit and the top level.

package srct_pkg;

	// Fixed point fraction bits (Q16.16)
	localparam int FB = 16;

	// Width of a ray parameter t; t of 2^T_W or more is beyond any range
	localparam int T_W = 31;

	// Largest scaled cross term whose square is formed
	localparam int XM_LIM = 1 << 18;

	// Quotient bits resolved per divider stage, root bits per square root stage
	localparam int DIV_SPS  = 4;
	localparam int SQRT_SPS = 6;

	// Reset value of the tolerance register
	localparam logic [15:0] EPS_RST = 16'd66;

endpackage

// ----- sv/shadow_ray_cylinder_test.sv -----
// Shadow ray test against a unit capped cylinder (radius 1, y in [-1,1]) in Q16.16.
// One ray beat is taken every clock while the output is not stalled; the shadowed
// flag comes after four setup stages, the 4-stage square root of the discriminant,
// one root stage, the 9-stage dividers (four quotient bits per stage) that form the
// ray parameters, and five stages of point checks. A stalled output holds the whole
// pipeline. The user must write epsilon through cfg_we/cfg_wdata only while idle;
// the block does not enforce it. Depends on srct_pkg, srct_sqrt and srct_div.

module shadow_ray_cylinder_test (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,   // epsilon
	input  logic         s_tvalid,
	output logic         s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, zero fill
	input  logic [183:0] s_tdata,
	input  logic [1:0]   s_tuser,     // bottom_closed, top_closed
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata      // shadowed, zero fill
);

	localparam int FB = srct_pkg::FB;
	localparam int TW = srct_pkg::T_W;

	typedef struct packed {
		logic signed [50:0] h;
		logic [35:0]        a;
		logic signed [31:0] oy;
		logic signed [31:0] ox;
		logic signed [31:0] oz;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
		logic [30:0]        maxd;
		logic               bok;
		logic [32:0]        unb;
		logic [32:0]        unt;
		logic [17:0]        ud;
		logic               capok_b;
		logic               capok_t;
	} sq_side_t;

	typedef struct packed {
		logic signed [31:0] oy;
		logic signed [31:0] ox;
		logic signed [31:0] oz;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
		logic [30:0]        maxd;
		logic               bok;
		logic               okl;
	} dv_side_t;

	logic        ce;
	logic [15:0] eps_q;

	// Input fields
	logic signed [31:0] origin_x, origin_y, origin_z;
	logic signed [17:0] dir_x, dir_y, dir_z;
	logic [30:0]        max_distance;
	logic               bottom_closed, top_closed;

	assign origin_x      = signed'(s_tdata[31:0]);
	assign origin_y      = signed'(s_tdata[63:32]);
	assign origin_z      = signed'(s_tdata[95:64]);
	assign dir_x         = signed'(s_tdata[113:96]);
	assign dir_y         = signed'(s_tdata[131:114]);
	assign dir_z         = signed'(s_tdata[149:132]);
	assign max_distance  = s_tdata[180:150];
	assign bottom_closed = s_tuser[0];
	assign top_closed    = s_tuser[1];

	// Stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	assign ce       = !v_s10 || m_tready;
	assign s_tready = ce;

	// Hold the tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= srct_pkg::EPS_RST;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// ---------------- s1: products and cap plane offsets
	logic signed [35:0] dxx_s1, dzz_s1;
	logic signed [49:0] oxdx_s1, ozdz_s1, oxdz_s1, ozdx_s1;
	logic signed [32:0] nb_s1, nt_s1;
	logic signed [31:0] ox_s1, oy_s1, oz_s1;
	logic signed [17:0] dx_s1, dy_s1, dz_s1;
	logic [30:0]        maxd_s1;
	logic               bot_s1, top_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			dxx_s1  <= dir_x * dir_x;
			dzz_s1  <= dir_z * dir_z;
			oxdx_s1 <= origin_x * dir_x;
			ozdz_s1 <= origin_z * dir_z;
			oxdz_s1 <= origin_x * dir_z;
			ozdx_s1 <= origin_z * dir_x;
			nb_s1   <= -33'(1 << FB) - 33'(origin_y);
			nt_s1   <= 33'(1 << FB) - 33'(origin_y);
			ox_s1   <= origin_x;
			oy_s1   <= origin_y;
			oz_s1   <= origin_z;
			dx_s1   <= dir_x;
			dy_s1   <= dir_y;
			dz_s1   <= dir_z;
			maxd_s1 <= max_distance;
			bot_s1  <= bottom_closed;
			top_s1  <= top_closed;
		end
	end

	// ---------------- s2: quadratic terms, cap magnitudes and cap enables
	logic [35:0]        a_s2;
	logic signed [50:0] h_s2, x_s2;
	logic [32:0]        unb_s2, unt_s2;
	logic [17:0]        ud_s2;
	logic               capok_b_s2, capok_t_s2;
	logic signed [31:0] ox_s2, oy_s2, oz_s2;
	logic signed [17:0] dx_s2, dy_s2, dz_s2;
	logic [30:0]        maxd_s2;
	logic [17:0]        ud_c;
	logic               capdeg_c;

	always_comb begin
		ud_c     = dy_s1[17] ? 18'(-dy_s1) : 18'(dy_s1);
		capdeg_c = (dy_s1 != 0) && (ud_c >= 18'(eps_q));
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			a_s2       <= 36'(dxx_s1) + 36'(dzz_s1);
			h_s2       <= 51'(oxdx_s1) + 51'(ozdz_s1);
			x_s2       <= 51'(oxdz_s1) - 51'(ozdx_s1);
			unb_s2     <= nb_s1[32] ? 33'(-nb_s1) : 33'(nb_s1);
			unt_s2     <= nt_s1[32] ? 33'(-nt_s1) : 33'(nt_s1);
			ud_s2      <= ud_c;
			capok_b_s2 <= bot_s1 && capdeg_c && (nb_s1 != 0) && (nb_s1[32] == dy_s1[17]);
			capok_t_s2 <= top_s1 && capdeg_c && (nt_s1 != 0) && (nt_s1[32] == dy_s1[17]);
			ox_s2      <= ox_s1;
			oy_s2      <= oy_s1;
			oz_s2      <= oz_s1;
			dx_s2      <= dx_s1;
			dy_s2      <= dy_s1;
			dz_s2      <= dz_s1;
			maxd_s2    <= maxd_s1;
		end
	end

	// ---------------- s3: scaled cross term and body degeneracy
	logic [50:0]        xabs_c;
	logic [50-FB:0]     xm_s3;
	logic               aok_s3;
	sq_side_t           sd_s3;

	assign xabs_c = x_s2[50] ? 51'(-x_s2) : 51'(x_s2);

	always_ff @(posedge clk) begin
		if (ce) begin
			xm_s3           <= xabs_c[50:FB];
			aok_s3          <= (a_s2 != 0) && (a_s2 >= (36'(eps_q) << FB));
			sd_s3.h         <= h_s2;
			sd_s3.a         <= a_s2;
			sd_s3.oy        <= oy_s2;
			sd_s3.ox        <= ox_s2;
			sd_s3.oz        <= oz_s2;
			sd_s3.dx        <= dx_s2;
			sd_s3.dy        <= dy_s2;
			sd_s3.dz        <= dz_s2;
			sd_s3.maxd      <= maxd_s2;
			sd_s3.bok       <= 1'b0;
			sd_s3.unb       <= unb_s2;
			sd_s3.unt       <= unt_s2;
			sd_s3.ud        <= ud_s2;
			sd_s3.capok_b   <= capok_b_s2;
			sd_s3.capok_t   <= capok_t_s2;
		end
	end

	// ---------------- s4: square of the cross term
	logic [37:0] xm2_s4;
	logic        bok_s4;
	sq_side_t    sd_s4;

	always_ff @(posedge clk) begin
		if (ce) begin
			xm2_s4 <= xm_s3[18:0] * xm_s3[18:0];
			bok_s4 <= aok_s3 && (xm_s3 <= (50-FB+1)'(srct_pkg::XM_LIM));
			sd_s4  <= sd_s3;
		end
	end

	// Discriminant into the square root unit
	logic [35:0] rad_c;
	sq_side_t    sq_in_c;
	sq_side_t    sq_out;
	logic        sq_valid;
	logic [17:0] sq_root;

	always_comb begin
		sq_in_c     = sd_s4;
		sq_in_c.bok = bok_s4 && (xm2_s4 <= {2'b00, sd_s4.a});
		rad_c       = sd_s4.a - xm2_s4[35:0];
	end

	srct_sqrt #(
		.RW  (18),
		.SPS (srct_pkg::SQRT_SPS),
		.SW  ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s4),
		.rad       (rad_c),
		.side_in   (sq_in_c),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_out)
	);

	// ---------------- s5: root numerators
	logic signed [51:0] sh_c, numlo_c, numhi_c;
	logic signed [51:0] numlo_s5, numhi_s5;
	logic               okh_s5;
	logic [35:0]        a_s5;
	logic [32:0]        unb_s5, unt_s5;
	logic [17:0]        ud_s5;
	logic               capok_b_s5, capok_t_s5;
	dv_side_t           dv_s5;

	always_comb begin
		sh_c    = signed'(52'({sq_root, {FB{1'b0}}}));
		numlo_c = -52'(sq_out.h) - sh_c;
		numhi_c = -52'(sq_out.h) + sh_c;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			numlo_s5    <= numlo_c;
			numhi_s5    <= numhi_c;
			okh_s5      <= !numhi_c[51] && (numhi_c != 0);
			a_s5        <= sq_out.a;
			unb_s5      <= sq_out.unb;
			unt_s5      <= sq_out.unt;
			ud_s5       <= sq_out.ud;
			capok_b_s5  <= sq_out.capok_b;
			capok_t_s5  <= sq_out.capok_t;
			dv_s5.oy    <= sq_out.oy;
			dv_s5.ox    <= sq_out.ox;
			dv_s5.oz    <= sq_out.oz;
			dv_s5.dx    <= sq_out.dx;
			dv_s5.dy    <= sq_out.dy;
			dv_s5.dz    <= sq_out.dz;
			dv_s5.maxd  <= sq_out.maxd;
			dv_s5.bok   <= sq_out.bok;
			dv_s5.okl   <= !numlo_c[51] && (numlo_c != 0);
		end
	end

	// Ray parameters for both body roots and both cap planes
	logic [TW-1:0] tlo, thi, tb, tt;
	logic          ovf_lo, ovf_hi, ovf_b, ovf_t;
	logic          vd_lo, vd_hi, vd_b, vd_t;
	dv_side_t      dv_out;
	logic          okh_d, capok_b_d, capok_t_d;

	srct_div #(
		.NW (51 + FB), .DW (36), .QW (TW), .SPS (srct_pkg::DIV_SPS),
		.SW ($bits(dv_side_t))
	) u_div_lo (
		.clk (clk), .arst_n (arst_n), .ce (ce), .in_valid (v_s5),
		.num ({numlo_s5[50:0], {FB{1'b0}}}), .den (a_s5), .side_in (dv_s5),
		.out_valid (vd_lo), .quo (tlo), .ovf (ovf_lo), .side_out (dv_out)
	);

	srct_div #(
		.NW (51 + FB), .DW (36), .QW (TW), .SPS (srct_pkg::DIV_SPS), .SW (1)
	) u_div_hi (
		.clk (clk), .arst_n (arst_n), .ce (ce), .in_valid (v_s5),
		.num ({numhi_s5[50:0], {FB{1'b0}}}), .den (a_s5), .side_in (okh_s5),
		.out_valid (vd_hi), .quo (thi), .ovf (ovf_hi), .side_out (okh_d)
	);

	srct_div #(
		.NW (33 + FB), .DW (18), .QW (TW), .SPS (srct_pkg::DIV_SPS), .SW (1)
	) u_div_bot (
		.clk (clk), .arst_n (arst_n), .ce (ce), .in_valid (v_s5),
		.num ({unb_s5, {FB{1'b0}}}), .den (ud_s5), .side_in (capok_b_s5),
		.out_valid (vd_b), .quo (tb), .ovf (ovf_b), .side_out (capok_b_d)
	);

	srct_div #(
		.NW (33 + FB), .DW (18), .QW (TW), .SPS (srct_pkg::DIV_SPS), .SW (1)
	) u_div_top (
		.clk (clk), .arst_n (arst_n), .ce (ce), .in_valid (v_s5),
		.num ({unt_s5, {FB{1'b0}}}), .den (ud_s5), .side_in (capok_t_s5),
		.out_valid (vd_t), .quo (tt), .ovf (ovf_t), .side_out (capok_t_d)
	);

	// ---------------- s6: point offsets along the ray and range checks
	logic signed [49:0] ylp_s6, yhp_s6, xbp_s6, zbp_s6, xtp_s6, ztp_s6;
	logic               rlo_s6, rhi_s6, rb_s6, rt_s6, bok_s6;
	logic signed [31:0] ox_s6, oy_s6, oz_s6;

	always_ff @(posedge clk) begin
		if (ce) begin
			ylp_s6 <= signed'({1'b0, tlo}) * dv_out.dy;
			yhp_s6 <= signed'({1'b0, thi}) * dv_out.dy;
			xbp_s6 <= signed'({1'b0, tb}) * dv_out.dx;
			zbp_s6 <= signed'({1'b0, tb}) * dv_out.dz;
			xtp_s6 <= signed'({1'b0, tt}) * dv_out.dx;
			ztp_s6 <= signed'({1'b0, tt}) * dv_out.dz;
			rlo_s6 <= dv_out.okl && !ovf_lo && (tlo > TW'(eps_q)) && (tlo < dv_out.maxd);
			rhi_s6 <= okh_d && !ovf_hi && (thi > TW'(eps_q)) && (thi < dv_out.maxd);
			rb_s6  <= capok_b_d && !ovf_b && (tb > TW'(eps_q)) && (tb < dv_out.maxd);
			rt_s6  <= capok_t_d && !ovf_t && (tt > TW'(eps_q)) && (tt < dv_out.maxd);
			bok_s6 <= dv_out.bok;
			ox_s6  <= dv_out.ox;
			oy_s6  <= dv_out.oy;
			oz_s6  <= dv_out.oz;
		end
	end

	// ---------------- s7: hit points
	logic signed [34:0] ylo_s7, yhi_s7, xb_s7, zb_s7, xt_s7, zt_s7;
	logic               rlo_s7, rhi_s7, rb_s7, rt_s7, bok_s7;

	always_ff @(posedge clk) begin
		if (ce) begin
			ylo_s7 <= 35'(oy_s6) + 35'(ylp_s6 >>> FB);
			yhi_s7 <= 35'(oy_s6) + 35'(yhp_s6 >>> FB);
			xb_s7  <= 35'(ox_s6) + 35'(xbp_s6 >>> FB);
			zb_s7  <= 35'(oz_s6) + 35'(zbp_s6 >>> FB);
			xt_s7  <= 35'(ox_s6) + 35'(xtp_s6 >>> FB);
			zt_s7  <= 35'(oz_s6) + 35'(ztp_s6 >>> FB);
			rlo_s7 <= rlo_s6;
			rhi_s7 <= rhi_s6;
			rb_s7  <= rb_s6;
			rt_s7  <= rt_s6;
			bok_s7 <= bok_s6;
		end
	end

	// ---------------- s8: body height check, cap point magnitudes
	logic [34:0] axb_c, azb_c, axt_c, azt_c;
	logic [30:0] axb_s8, azb_s8, axt_s8, azt_s8;
	logic        body_s8, cb_s8, ct_s8;

	always_comb begin
		axb_c = xb_s7[34] ? 35'(-xb_s7) : 35'(xb_s7);
		azb_c = zb_s7[34] ? 35'(-zb_s7) : 35'(zb_s7);
		axt_c = xt_s7[34] ? 35'(-xt_s7) : 35'(xt_s7);
		azt_c = zt_s7[34] ? 35'(-zt_s7) : 35'(zt_s7);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			body_s8 <= bok_s7 && (
				(rlo_s7 && (ylo_s7 >= -35'(1 << FB)) && (ylo_s7 <= 35'(1 << FB))) ||
				(rhi_s7 && (yhi_s7 >= -35'(1 << FB)) && (yhi_s7 <= 35'(1 << FB))));
			cb_s8   <= rb_s7 && (axb_c[34:31] == 0) && (azb_c[34:31] == 0);
			ct_s8   <= rt_s7 && (axt_c[34:31] == 0) && (azt_c[34:31] == 0);
			axb_s8  <= axb_c[30:0];
			azb_s8  <= azb_c[30:0];
			axt_s8  <= axt_c[30:0];
			azt_s8  <= azt_c[30:0];
		end
	end

	// ---------------- s9: squared cap radii
	logic [61:0] sxb_s9, szb_s9, sxt_s9, szt_s9;
	logic        body_s9, cb_s9, ct_s9;

	always_ff @(posedge clk) begin
		if (ce) begin
			sxb_s9  <= axb_s8 * axb_s8;
			szb_s9  <= azb_s8 * azb_s8;
			sxt_s9  <= axt_s8 * axt_s8;
			szt_s9  <= azt_s8 * azt_s8;
			body_s9 <= body_s8;
			cb_s9   <= cb_s8;
			ct_s9   <= ct_s8;
		end
	end

	// ---------------- s10: cap radius compare and output register
	logic [62:0] lim_c;
	logic        shad_s10;

	assign lim_c = (63'(1) << (2 * FB)) + (63'(eps_q) << FB);

	always_ff @(posedge clk) begin
		if (ce) begin
			shad_s10 <= body_s9 ||
				(cb_s9 && ((63'(sxb_s9) + 63'(szb_s9)) <= lim_c)) ||
				(ct_s9 && ((63'(sxt_s9) + 63'(szt_s9)) <= lim_c));
		end
	end

	// Advance stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (ce) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= sq_valid;
			v_s6  <= vd_lo && vd_hi && vd_b && vd_t;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = {7'b0, shad_s10};

endmodule

// ----- sv/srct_div.sv -----
// Pipelined restoring divider with overflow detect and a sideband bus.
// Uses srct_pkg for the default number of quotient bits per stage.

module srct_div #(
	parameter int NW  = 67,
	parameter int DW  = 36,
	parameter int QW  = srct_pkg::T_W,
	parameter int SPS = srct_pkg::DIV_SPS,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [SW-1:0] side_out
);

	localparam int NST = (QW + SPS - 1) / SPS;
	localparam int HW  = NW - QW;
	localparam int PW  = DW + 1 + QW + QW;

	logic          v_s    [NST+1];
	logic [DW:0]   rem_s  [NST+1];
	logic [QW-1:0] low_s  [NST+1];
	logic [QW-1:0] q_s    [NST+1];
	logic [DW-1:0] den_s  [NST+1];
	logic          ovf_s  [NST+1];
	logic [SW-1:0] side_s [NST+1];
	logic [HW-1:0] hi;

	// Resolve up to SPS quotient bits, starting at quotient bit number first
	function automatic logic [PW-1:0] div_steps(input logic [DW:0] r_in,
			input logic [QW-1:0] l_in, input logic [QW-1:0] q_in,
			input logic [DW-1:0] d, input int first);
		logic [DW:0]   r;
		logic [QW-1:0] l;
		logic [QW-1:0] q;
		r = r_in;
		l = l_in;
		q = q_in;
		for (int j = 0; j < SPS; j++) begin
			if (first + j < QW) begin
				r = {r[DW-1:0], l[QW-1]};
				l = {l[QW-2:0], 1'b0};
				if (r >= {1'b0, d}) begin
					r = r - {1'b0, d};
					q = {q[QW-2:0], 1'b1};
				end else begin
					q = {q[QW-2:0], 1'b0};
				end
			end
		end
		return {r, l, q};
	endfunction

	assign hi = num[NW-1:QW];

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) v_s[k] <= 1'b0;
		end else if (ce) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < NST; k++) v_s[k+1] <= v_s[k];
		end
	end

	// Load the upper dividend bits, then shift one quotient bit per step
	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0]  <= (DW+1)'(hi);
			low_s[0]  <= num[QW-1:0];
			q_s[0]    <= '0;
			den_s[0]  <= den;
			ovf_s[0]  <= ({{DW{1'b0}}, hi} >= {{HW{1'b0}}, den});
			side_s[0] <= side_in;
			for (int k = 0; k < NST; k++) begin
				{rem_s[k+1], low_s[k+1], q_s[k+1]} <=
					div_steps(rem_s[k], low_s[k], q_s[k], den_s[k], k * SPS);
				den_s[k+1]  <= den_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[NST];
	assign quo       = q_s[NST];
	assign ovf       = ovf_s[NST];
	assign side_out  = side_s[NST];

endmodule

// ----- sv/srct_sqrt.sv -----
// Pipelined digit-by-digit integer square root with a sideband bus.
// Uses srct_pkg for the default number of root bits per stage.

module srct_sqrt #(
	parameter int RW  = 18,
	parameter int SPS = srct_pkg::SQRT_SPS,
	parameter int SW  = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ce,
	input  logic            in_valid,
	input  logic [2*RW-1:0] rad,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);

	localparam int NST = (RW + SPS - 1) / SPS;
	localparam int PW  = RW + 2 + 2 * RW + RW;

	logic            v_s    [NST+1];
	logic [RW+1:0]   rem_s  [NST+1];
	logic [2*RW-1:0] val_s  [NST+1];
	logic [RW-1:0]   rt_s   [NST+1];
	logic [SW-1:0]   side_s [NST+1];

	// Resolve up to SPS root bits, starting at root bit number first
	function automatic logic [PW-1:0] sq_steps(input logic [RW+1:0] r_in,
			input logic [2*RW-1:0] v_in, input logic [RW-1:0] rt_in, input int first);
		logic [RW+1:0]   r;
		logic [2*RW-1:0] v;
		logic [RW-1:0]   rt;
		logic [RW+3:0]   rs;
		logic [RW+3:0]   tr;
		r  = r_in;
		v  = v_in;
		rt = rt_in;
		for (int j = 0; j < SPS; j++) begin
			if (first + j < RW) begin
				rs = {r, v[2*RW-1:2*RW-2]};
				v  = {v[2*RW-3:0], 2'b00};
				tr = {2'b00, rt, 2'b01};
				if (rs >= tr) begin
					rs = rs - tr;
					rt = {rt[RW-2:0], 1'b1};
				end else begin
					rt = {rt[RW-2:0], 1'b0};
				end
				r = rs[RW+1:0];
			end
		end
		return {r, v, rt};
	endfunction

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) v_s[k] <= 1'b0;
		end else if (ce) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < NST; k++) v_s[k+1] <= v_s[k];
		end
	end

	// Take two radicand bits per step, top first
	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0]  <= '0;
			val_s[0]  <= rad;
			rt_s[0]   <= '0;
			side_s[0] <= side_in;
			for (int k = 0; k < NST; k++) begin
				{rem_s[k+1], val_s[k+1], rt_s[k+1]} <=
					sq_steps(rem_s[k], val_s[k], rt_s[k], k * SPS);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[NST];
	assign root      = rt_s[NST];
	assign side_out  = side_s[NST];

endmodule
